[design/qst_pkg.sv]
package qst_pkg;

   localparam int unsigned NumDelims = 4;
   localparam int unsigned QueueDepth = 4;

   typedef enum logic [2:0] {
      MODE_START  = 3'd0,
      MODE_NORMAL = 3'd1,
      MODE_DQ     = 3'd2,
      MODE_SQ     = 3'd3,
      MODE_BSL    = 3'd4,
      MODE_DQESC  = 3'd5,
      MODE_MERGE  = 3'd6,
      MODE_DROP   = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_FIELD  = 2'd1,
      KIND_RECORD = 2'd2,
      KIND_ERROR  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      REG_DELIM_A = 3'd0,
      REG_DELIM_B = 3'd1,
      REG_DELIM_C = 3'd2,
      REG_DELIM_D = 3'd3,
      REG_USED    = 3'd4,
      REG_MERGE   = 3'd5
   } reg_index_type;

   localparam logic [7:0] CharDquote = 8'h22;
   localparam logic [7:0] CharSquote = 8'h27;
   localparam logic [7:0] CharBslash = 8'h5C;
   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharLowN   = 8'h6E;
   localparam logic [7:0] CharLowR   = 8'h72;
   localparam logic [7:0] CharLowT   = 8'h74;
   localparam logic [7:0] ByteLf     = 8'h0A;
   localparam logic [7:0] ByteCr     = 8'h0D;
   localparam logic [7:0] ByteTab    = 8'h09;
   localparam logic [7:0] ByteMax    = 8'hFF;
   localparam logic [15:0] CountMax  = 16'hFFFF;

   typedef struct packed {
      logic [NumDelims-1:0][7:0] delim;
      logic [2:0]                used;
      logic                      merge;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [15:0] field_count;
      logic        last;
   } result_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == CountMax) ? CountMax : v + 16'd1;
   endfunction

   function automatic logic is_delim(input cfg_type cfg, input logic [7:0] c);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NumDelims; i++) begin
         if ((cfg.used > 3'(i)) && (cfg.delim[i] == c)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic result_type make_result(input kind_type kind,
                                              input logic [7:0] b,
                                              input logic [15:0] cnt);
      result_type r;
      r.kind = kind;
      r.out_byte = b;
      r.field_count = cnt;
      r.last = 1'b0;
      return r;
   endfunction

endpackage

[design/qst_step.sv]
module qst_step (
   input  logic                 end_mark,
   input  logic [7:0]           char_byte,
   input  qst_pkg::cfg_type     cfg,
   input  qst_pkg::mode_type    mode_ff,
   input  logic [8:0]           esc_ff,
   input  logic [15:0]          cnt_ff,
   output qst_pkg::mode_type    mode_in,
   output logic [8:0]           esc_in,
   output logic [15:0]          cnt_in,
   output qst_pkg::result_type  res0,
   output qst_pkg::result_type  res1,
   output logic [1:0]           nres
);

   logic        done;
   logic        digit;
   logic [11:0] dec_val;
   qst_pkg::result_type r;

   always_comb begin
      mode_in = mode_ff;
      esc_in = esc_ff;
      cnt_in = cnt_ff;
      res0 = '0;
      res1 = '0;
      nres = 2'd0;
      done = 1'b0;
      r = '0;
      digit = (char_byte >= qst_pkg::CharZero) && (char_byte <= qst_pkg::CharNine);
      dec_val = {1'b0, esc_ff[7:0], 3'b000} + {3'b000, esc_ff[7:0], 1'b0}
              + {4'd0, char_byte - qst_pkg::CharZero};

      if (end_mark) begin
         if (mode_ff == qst_pkg::MODE_START || mode_ff == qst_pkg::MODE_NORMAL ||
             mode_ff == qst_pkg::MODE_MERGE) begin
            res0 = qst_pkg::make_result(qst_pkg::KIND_RECORD, 8'd0,
                                        qst_pkg::sat_inc(cnt_ff));
            nres = 2'd1;
         end else if (mode_ff != qst_pkg::MODE_DROP) begin
            res0 = qst_pkg::make_result(qst_pkg::KIND_ERROR, 8'd0, cnt_ff);
            nres = 2'd1;
         end
         mode_in = qst_pkg::MODE_START;
         esc_in = '0;
         cnt_in = '0;
         done = 1'b1;
      end

      if (!done && mode_in == qst_pkg::MODE_DQESC && esc_in[8]) begin
         if (digit) begin
            if (dec_val > 12'd255) begin
               res0 = qst_pkg::make_result(qst_pkg::KIND_ERROR, 8'd0, cnt_in);
               nres = 2'd1;
               mode_in = qst_pkg::MODE_DROP;
               esc_in = '0;
            end else begin
               esc_in = {1'b1, dec_val[7:0]};
            end
            done = 1'b1;
         end else begin
            res0 = qst_pkg::make_result(qst_pkg::KIND_DATA, esc_in[7:0], cnt_in);
            nres = 2'd1;
            esc_in = '0;
            mode_in = qst_pkg::MODE_DQ;
         end
      end

      if (!done && mode_in == qst_pkg::MODE_MERGE) begin
         if (qst_pkg::is_delim(cfg, char_byte)) begin
            done = 1'b1;
         end else begin
            mode_in = qst_pkg::MODE_START;
         end
      end

      if (!done && mode_in == qst_pkg::MODE_START) begin
         if (char_byte == qst_pkg::CharDquote) begin
            mode_in = qst_pkg::MODE_DQ;
            done = 1'b1;
         end else if (char_byte == qst_pkg::CharSquote) begin
            mode_in = qst_pkg::MODE_SQ;
            done = 1'b1;
         end else begin
            mode_in = qst_pkg::MODE_NORMAL;
         end
      end

      if (!done) begin
         r = qst_pkg::make_result(qst_pkg::KIND_DATA, char_byte, cnt_in);
         case (mode_in)
            qst_pkg::MODE_NORMAL: begin
               if (qst_pkg::is_delim(cfg, char_byte)) begin
                  cnt_in = qst_pkg::sat_inc(cnt_in);
                  r = qst_pkg::make_result(qst_pkg::KIND_FIELD, 8'd0, cnt_in);
                  mode_in = cfg.merge ? qst_pkg::MODE_MERGE : qst_pkg::MODE_START;
                  done = 1'b0;
               end else if (char_byte == qst_pkg::CharDquote) begin
                  mode_in = qst_pkg::MODE_DQ;
                  done = 1'b1;
               end else if (char_byte == qst_pkg::CharSquote) begin
                  mode_in = qst_pkg::MODE_SQ;
                  done = 1'b1;
               end else if (char_byte == qst_pkg::CharBslash) begin
                  mode_in = qst_pkg::MODE_BSL;
                  done = 1'b1;
               end
            end
            qst_pkg::MODE_DQ: begin
               if (char_byte == qst_pkg::CharDquote) begin
                  mode_in = qst_pkg::MODE_NORMAL;
                  done = 1'b1;
               end else if (char_byte == qst_pkg::CharBslash) begin
                  mode_in = qst_pkg::MODE_DQESC;
                  esc_in = '0;
                  done = 1'b1;
               end
            end
            qst_pkg::MODE_SQ: begin
               if (char_byte == qst_pkg::CharSquote) begin
                  mode_in = qst_pkg::MODE_NORMAL;
                  done = 1'b1;
               end
            end
            qst_pkg::MODE_BSL: begin
               mode_in = qst_pkg::MODE_NORMAL;
            end
            qst_pkg::MODE_DQESC: begin
               mode_in = qst_pkg::MODE_DQ;
               if (char_byte == qst_pkg::CharBslash || char_byte == qst_pkg::CharDquote) begin
                  r.out_byte = char_byte;
               end else if (char_byte == qst_pkg::CharLowN) begin
                  r.out_byte = qst_pkg::ByteLf;
               end else if (char_byte == qst_pkg::CharLowR) begin
                  r.out_byte = qst_pkg::ByteCr;
               end else if (char_byte == qst_pkg::CharLowT) begin
                  r.out_byte = qst_pkg::ByteTab;
               end else if (digit) begin
                  esc_in = {1'b1, char_byte - qst_pkg::CharZero};
                  mode_in = qst_pkg::MODE_DQESC;
                  done = 1'b1;
               end else begin
                  done = 1'b1;
               end
            end
            default: begin
               done = 1'b1;
            end
         endcase
         if (!done) begin
            if (nres == 2'd0) begin
               res0 = r;
            end else begin
               res1 = r;
            end
            nres = nres + 2'd1;
         end
      end

      if (nres == 2'd1) begin
         res0.last = 1'b1;
      end else if (nres == 2'd2) begin
         res1.last = 1'b1;
      end
   end

endmodule

[design/qst_queue.sv]
module qst_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_n,
   input  qst_pkg::result_type push0,
   input  qst_pkg::result_type push1,
   output logic                room,
   output logic                out_valid,
   input  logic                out_stall,
   output qst_pkg::result_type out_res
);

   localparam int unsigned PtrW = $clog2(qst_pkg::QueueDepth);
   localparam int unsigned CntW = $clog2(qst_pkg::QueueDepth + 1);

   qst_pkg::result_type entry_ff [qst_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;
   logic [PtrW-1:0] wr_next;

   assign out_valid = (count_ff != '0);
   assign out_res = entry_ff[rd_ptr_ff];
   assign pop = out_valid && !out_stall;
   assign room = (count_ff <= CntW'(qst_pkg::QueueDepth - 2));
   assign wr_next = wr_ptr_ff + PtrW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      count_in = count_ff + CntW'(push_n) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_next] <= push1;
      end
   end

endmodule

[design/quoted_string_tokenizer.sv]
// Quoted string tokenizer.
// req channel: one character (req_char_byte) or an end-of-string mark
// (req_end_mark) per transfer; a transfer happens when req_valid is high and
// req_stall is low. rsp channel: result items (kind, byte, field count, last)
// with the same valid/stall rule. Each character gives zero, one or two
// results; rsp_last marks the final result of a character.
// csr channel: register writes (index 0..5: delimiters a..d, delimiter count,
// merge enable), taken whenever csr_valid is high; csr_ready is always high.
// Write registers only while the block is idle.
// A character is registered in the input stage at its transfer and decoded
// from there once the queue has room; its results are written to the queue.
// Throughput: one character per cycle while the queue has room, set by the
// single decode stage; a character with two results is offered one at a time.
// A four-entry result queue decouples the sides, so req keeps moving while
// rsp is stalled until the queue cannot take two more results; then req_stall
// rises while a character waits in the input stage, and drops once the
// receiver has freed room for two results.
// Reset (synchronous, active high) empties the queue and input stage, returns
// the parser to field start and loads the register defaults.
module quoted_string_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_mark,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_field_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_char_ff;
   logic                in_end_ff;
   qst_pkg::cfg_type    cfg_ff, cfg_in;
   qst_pkg::mode_type   mode_ff, mode_in;
   logic [8:0]          esc_ff, esc_in;
   logic [15:0]         cnt_ff, cnt_in;
   qst_pkg::result_type res0, res1, head;
   logic [1:0]          nres;
   logic [1:0]          push_n;
   logic                room;
   logic                proc;
   logic                accept;

   assign csr_ready = 1'b1;
   assign proc = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !proc);
   assign push_n = proc ? nres : 2'd0;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            qst_pkg::REG_DELIM_A: cfg_in.delim[0] = csr_data;
            qst_pkg::REG_DELIM_B: cfg_in.delim[1] = csr_data;
            qst_pkg::REG_DELIM_C: cfg_in.delim[2] = csr_data;
            qst_pkg::REG_DELIM_D: cfg_in.delim[3] = csr_data;
            qst_pkg::REG_USED:    cfg_in.used = csr_data[2:0];
            qst_pkg::REG_MERGE:   cfg_in.merge = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cfg_ff.delim <= {8'd0, 8'd0, 8'd0, 8'd44};
         cfg_ff.used <= 3'd1;
         cfg_ff.merge <= 1'b0;
         mode_ff <= qst_pkg::MODE_START;
         esc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff <= cfg_in;
         if (proc) begin
            mode_ff <= mode_in;
            esc_ff <= esc_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_char_byte;
         in_end_ff <= req_end_mark;
      end
   end

   qst_step u_step (
      .end_mark  (in_end_ff),
      .char_byte (in_char_ff),
      .cfg       (cfg_ff),
      .mode_ff   (mode_ff),
      .esc_ff    (esc_ff),
      .cnt_ff    (cnt_ff),
      .mode_in   (mode_in),
      .esc_in    (esc_in),
      .cnt_in    (cnt_in),
      .res0      (res0),
      .res1      (res1),
      .nres      (nres)
   );

   qst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_n    (push_n),
      .push0     (res0),
      .push1     (res1),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (head)
   );

   assign rsp_kind = head.kind;
   assign rsp_out_byte = head.out_byte;
   assign rsp_field_count = head.field_count;
   assign rsp_last = head.last;

endmodule
